/* rtl/fpdf_pkg.sv */
// Shared types and constants for the fixed-point decimal formatter.
// Used by every module of the block; has no dependencies of its own.
package fpdf_pkg;

  localparam int MAX_CHARS = 32;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Decimal digits of a 32-bit magnitude and their packed BCD form.
  localparam int NUM_DIG   = 10;
  localparam int DIG_IDX_W = $clog2(NUM_DIG);
  localparam int NDIG_W    = $clog2(NUM_DIG + 1);
  localparam int BCD_W     = 4 * NUM_DIG;

  // One shift-and-adjust step per bit of the magnitude.
  localparam int CONV_STEPS = VALUE_W;
  localparam int CONV_CNT_W = $clog2(CONV_STEPS);

  // Field length int_digits + frac_digits + 1 is at most 31.
  localparam int LEN_W  = CFG_W + 1;
  localparam int STOP_W = LEN_W + 2;
  localparam logic [LEN_W-1:0] EMIT_CAP =
    LEN_W'(((MAX_CHARS - 1) < (2 ** LEN_W - 1)) ? (MAX_CHARS - 1) : (2 ** LEN_W - 1));

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [CFG_W-1:0]  INT_DIGITS_RST  = 4'd3;
  localparam logic [CFG_W-1:0]  FRAC_DIGITS_RST = 4'd1;
  localparam logic [CHAR_W-1:0] SIGN_CHAR_RST   = 8'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INT_DIGITS  = 2'd0,
    CFG_FRAC_DIGITS = 2'd1,
    CFG_SIGN_CHAR   = 2'd2
  } cfg_reg_e;

  // Everything the emitter needs to lay out one field.
  typedef struct packed {
    logic [BCD_W-1:0]         bcd;   // decimal digits, least significant first
    logic [LEN_W-1:0]         len;   // field length
    logic [LEN_W-1:0]         vk;    // position of the point
    logic                     fr;    // point present
    logic signed [STOP_W-1:0] stop;  // sign position, negative if none
    logic [CHAR_W-1:0]        sgn;   // sign character
  } fpdf_rec_t;

endpackage

/* rtl/fpdf_front.sv */
// Front end of the formatter: accepts a value, converts its magnitude to BCD
// by shift-and-add-3 and works out the field layout. Uses fpdf_pkg.
module fpdf_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [fpdf_pkg::VALUE_W-1:0]     value_i,
  input  logic [fpdf_pkg::CFG_W-1:0]              int_digits_i,
  input  logic [fpdf_pkg::CFG_W-1:0]              frac_digits_i,
  input  logic [fpdf_pkg::CHAR_W-1:0]             sign_char_i,
  output logic                                    push_o,
  output fpdf_pkg::fpdf_rec_t                     rec_o,
  input  logic                                    full_i
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_e;

  front_state_e                          state_q, state_d;
  logic [fpdf_pkg::CONV_CNT_W-1:0]       cnt_q, cnt_d;
  logic [fpdf_pkg::VALUE_W-1:0]          bin_q, bin_d;
  logic [fpdf_pkg::BCD_W-1:0]            bcd_q, bcd_d;
  logic [fpdf_pkg::BCD_W-1:0]            bcd_adj;
  logic                                  zero_q, zero_d;
  logic [fpdf_pkg::CFG_W-1:0]            int_q, int_d;
  logic [fpdf_pkg::CFG_W-1:0]            frac_q, frac_d;
  logic [fpdf_pkg::CHAR_W-1:0]           sgn_q, sgn_d;
  logic                                  accept;
  logic [fpdf_pkg::NDIG_W-1:0]           ndig;
  logic                                  fr;
  logic [fpdf_pkg::LEN_W-1:0]            len;
  logic signed [fpdf_pkg::STOP_W-1:0]    t_point, t_digits, stop;

  assign in_stall_o = (state_q != F_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Add 3 to every digit of 5 or more before the next shift.
  always_comb begin
    for (int k = 0; k < fpdf_pkg::NUM_DIG; k++) begin
      bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3
                                                     : bcd_q[4*k +: 4];
    end
  end

  // Number of significant decimal digits.
  always_comb begin
    ndig = '0;
    for (int k = 0; k < fpdf_pkg::NUM_DIG; k++) begin
      if (bcd_q[4*k +: 4] != 4'd0) begin
        ndig = fpdf_pkg::NDIG_W'(k + 1);
      end
    end
  end

  // The sign goes at the first position, counting from the right, that is
  // neither forced to a digit nor needed for the remaining magnitude.
  always_comb begin
    fr       = (frac_q != '0);
    len      = {1'b0, int_q} + {1'b0, frac_q} + fpdf_pkg::LEN_W'(1);
    t_point  = $signed({3'b000, int_q}) - (fr ? fpdf_pkg::STOP_W'(2) : '0);
    t_digits = $signed({2'b00, len} - fpdf_pkg::STOP_W'(1)
                       - fpdf_pkg::STOP_W'(fr) - fpdf_pkg::STOP_W'(ndig));
    if (zero_q) begin
      stop = t_point - fpdf_pkg::STOP_W'(1);
    end else if (t_digits < t_point) begin
      stop = t_digits;
    end else begin
      stop = t_point;
    end
  end

  always_comb begin
    rec_o.bcd  = bcd_q;
    rec_o.len  = len;
    rec_o.vk   = {1'b0, int_q};
    rec_o.fr   = fr;
    rec_o.stop = stop;
    rec_o.sgn  = sgn_q;
    push_o     = (state_q == F_PUSH) && !full_i;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    zero_d  = zero_q;
    int_d   = int_q;
    frac_d  = frac_q;
    sgn_d   = sgn_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          bin_d   = value_i[fpdf_pkg::VALUE_W-1] ? 0 - value_i : value_i;
          bcd_d   = '0;
          cnt_d   = '0;
          zero_d  = (value_i == '0);
          int_d   = int_digits_i;
          frac_d  = frac_digits_i;
          sgn_d   = value_i[fpdf_pkg::VALUE_W-1] ? fpdf_pkg::CH_MINUS : sign_char_i;
          state_d = F_CONV;
        end
      end
      F_CONV: begin
        bcd_d = {bcd_adj[fpdf_pkg::BCD_W-2:0], bin_q[fpdf_pkg::VALUE_W-1]};
        bin_d = {bin_q[fpdf_pkg::VALUE_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == fpdf_pkg::CONV_CNT_W'(fpdf_pkg::CONV_STEPS - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    zero_q <= zero_d;
    int_q  <= int_d;
    frac_q <= frac_d;
    sgn_q  <= sgn_d;
  end

`ifndef SYNTHESIS
  // Conversion always runs its full length before the layout is offered.
  a_conv_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_CONV) && (cnt_q != fpdf_pkg::CONV_CNT_W'(fpdf_pkg::CONV_STEPS - 1))
    |=> (state_q == F_CONV))
    else $error("conversion left early");
  // A new value is only taken once the previous layout has been queued.
  a_push_then_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (state_q == F_IDLE))
    else $error("front did not return to idle after queuing");
`endif

endmodule

/* rtl/fpdf_fifo.sv */
// Short queue of field layouts between the front end and the emitter.
// Uses fpdf_pkg for the record type and depth.
module fpdf_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fpdf_pkg::fpdf_rec_t wdata_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output fpdf_pkg::fpdf_rec_t rdata_o
);

  fpdf_pkg::fpdf_rec_t                 mem_q [fpdf_pkg::FIFO_DEPTH];
  logic [fpdf_pkg::FIFO_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [fpdf_pkg::FIFO_CNT_W-1:0]     cnt_q;

  assign full_o  = (cnt_q == fpdf_pkg::FIFO_CNT_W'(fpdf_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == fpdf_pkg::FIFO_PTR_W'(fpdf_pkg::FIFO_DEPTH - 1))
                    ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == fpdf_pkg::FIFO_PTR_W'(fpdf_pkg::FIFO_DEPTH - 1))
                    ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");
`endif

endmodule

/* rtl/fpdf_back.sv */
// Emitter of the formatter, using fpdf_pkg: walks one queued field left to
// right, one character per cycle unless stalled, into the output register.
module fpdf_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  fpdf_pkg::fpdf_rec_t            rec_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [fpdf_pkg::CHAR_W-1:0]    character_o,
  output logic                           last_o
);

  logic [fpdf_pkg::LEN_W-1:0]  pos_q, pos_d;
  logic                        valid_q, valid_d;
  logic [fpdf_pkg::CHAR_W-1:0] char_q, char_d;
  logic                        last_q, last_d;
  logic [fpdf_pkg::LEN_W-1:0]  n_emit, j;
  logic [3:0]                  dig [fpdf_pkg::NUM_DIG];
  logic [3:0]                  digit;
  logic [fpdf_pkg::CHAR_W-1:0] ch;
  logic                        load, at_end;

  always_comb begin
    for (int k = 0; k < fpdf_pkg::NUM_DIG; k++) begin
      dig[k] = rec_i.bcd[4*k +: 4];
    end
  end

  // Character at the current position of the field.
  always_comb begin
    n_emit = (rec_i.len > fpdf_pkg::EMIT_CAP) ? fpdf_pkg::EMIT_CAP : rec_i.len;
    j      = (rec_i.fr && (pos_q < rec_i.vk)) ? rec_i.len - fpdf_pkg::LEN_W'(2) - pos_q
                                              : rec_i.len - fpdf_pkg::LEN_W'(1) - pos_q;
    digit  = (j < fpdf_pkg::LEN_W'(fpdf_pkg::NUM_DIG)) ? dig[j[fpdf_pkg::DIG_IDX_W-1:0]]
                                                       : 4'd0;
    if ($signed({2'b00, pos_q}) > rec_i.stop) begin
      if (rec_i.fr && (pos_q == rec_i.vk)) begin
        ch = fpdf_pkg::CH_POINT;
      end else begin
        ch = fpdf_pkg::CH_ZERO + {4'd0, digit};
      end
    end else if ($signed({2'b00, pos_q}) == rec_i.stop) begin
      ch = rec_i.sgn;
    end else begin
      ch = fpdf_pkg::CH_SPACE;
    end
  end

  always_comb begin
    load    = !empty_i && (!valid_q || !out_stall_i);
    at_end  = (pos_q == n_emit - fpdf_pkg::LEN_W'(1));
    pop_o   = load && at_end;
    pos_d   = pos_q;
    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      char_d  = ch;
      last_d  = at_end;
      pos_d   = at_end ? '0 : pos_q + 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  // The queued layout is released exactly with the final character.
  a_pop_with_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_o && last_o))
    else $error("layout released without a final character");
  // The position restarts after the final character of a field.
  a_pos_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (pos_q == '0))
    else $error("position not reset after field end");
`endif

endmodule

/* rtl/fixed_point_decimal_formatter.sv */
// Top level of the fixed-point decimal formatter: configuration registers,
// front end, layout queue and emitter. Depends on fpdf_pkg and its submodules.
//
// Use: a signed 32-bit value enters on the input channel (in_valid_i, in_stall_o,
// value_i) and leaves as a right-justified ASCII field of
// int_digits + frac_digits + 1 characters on the output channel (out_valid_o,
// out_stall_i, character_o, last_o), leftmost character first, last_o marking
// the final one. A transaction completes at a rising edge with valid high and
// stall low.
// After the input transaction the front end runs its shift-and-add-3 BCD
// converter, one bit per cycle, and then queues the layout; the emitter then
// registers the first character, and a new one follows every cycle while
// out_stall_i is low. A value occupies the front end from its input
// transaction until its layout is queued, and then the emitter while its
// characters go out. A field has at most 31 characters, so the converter,
// not the emitter, sets the sustained rate of values when out_stall_i is low.
// The two-entry queue lets the front end convert the next value while the
// emitter is still sending, or is held by out_stall_i; a stalled character
// stays in the output register unchanged. Reset clears all control state and
// loads int_digits = 3, frac_digits = 1 and sign_char = space. The user must
// write registers through cfg_we_i, cfg_idx_i and cfg_data_i only while no
// value is in flight; the block does not enforce this. Index 3 is ignored.
module fixed_point_decimal_formatter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fpdf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [fpdf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [fpdf_pkg::VALUE_W-1:0]  value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [fpdf_pkg::CHAR_W-1:0]          character_o,
  output logic                                 last_o
);

  logic [fpdf_pkg::CFG_W-1:0]  int_digits_q;
  logic [fpdf_pkg::CFG_W-1:0]  frac_digits_q;
  logic [fpdf_pkg::CHAR_W-1:0] sign_char_q;

  logic                push, full, pop, empty;
  fpdf_pkg::fpdf_rec_t push_rec, head_rec;

  // Configuration registers; only the low bits of the data are kept for the
  // digit counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_digits_q  <= fpdf_pkg::INT_DIGITS_RST;
      frac_digits_q <= fpdf_pkg::FRAC_DIGITS_RST;
      sign_char_q   <= fpdf_pkg::SIGN_CHAR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fpdf_pkg::CFG_INT_DIGITS:  int_digits_q  <= cfg_data_i[fpdf_pkg::CFG_W-1:0];
        fpdf_pkg::CFG_FRAC_DIGITS: frac_digits_q <= cfg_data_i[fpdf_pkg::CFG_W-1:0];
        fpdf_pkg::CFG_SIGN_CHAR:   sign_char_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The front end converts the magnitude and works out where the sign goes.
  fpdf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .int_digits_i  (int_digits_q),
    .frac_digits_i (frac_digits_q),
    .sign_char_i   (sign_char_q),
    .push_o        (push),
    .rec_o         (push_rec),
    .full_i        (full)
  );

  // The queue decouples conversion from emission.
  fpdf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_rec),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (head_rec)
  );

  // The emitter turns the layout at the head of the queue into characters.
  fpdf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .rec_i       (head_rec),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

`ifndef SYNTHESIS
  // Characters only appear once a layout has been through the queue.
  a_out_needs_layout : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!empty))
    else $error("character produced without a queued layout");
`endif

endmodule
